// File: sv/utf8d_pkg.sv
package utf8d_pkg;

    // Queue depths
    localparam int CLASS_QUEUE_DEPTH  = 4;
    localparam int RESULT_QUEUE_DEPTH = 2;
    localparam int DEF_MAX_STRING_BYTES = 1024;

    localparam int COUNT_W = 11;
    localparam int UNIT_W  = 16;

    // Byte classes
    localparam logic [2:0] CLS_ASCII = 3'd0;
    localparam logic [2:0] CLS_CONT  = 3'd1;
    localparam logic [2:0] CLS_LEAD2 = 3'd2;
    localparam logic [2:0] CLS_LEAD3 = 3'd3;
    localparam logic [2:0] CLS_LEAD4 = 3'd4;
    localparam logic [2:0] CLS_BAD   = 3'd5;

    // End status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ILLEGAL   = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic               unit_valid;
        logic [UNIT_W-1:0]  code_unit;
        logic               string_end;
        logic [1:0]         status;
        logic [COUNT_W-1:0] unit_count;
    } t_out_word;

    // Classified byte passed from front to back
    typedef struct packed {
        logic [2:0] cls;
        logic [6:0] bits;
        logic       last;
    } t_class_word;

endpackage

// File: sv/utf8d_front.sv
module utf8d_front (
    input  utf8d_pkg::t_in_word    i_word,
    output utf8d_pkg::t_class_word o_entry
);

    logic [7:0] w_b;

    assign w_b = i_word.in_byte;

    // Classify the byte and strip its marker bits
    always_comb begin
        o_entry.last = i_word.last_byte;
        if (w_b[7] == 1'b0) begin
            o_entry.cls  = utf8d_pkg::CLS_ASCII;
            o_entry.bits = w_b[6:0];
        end else if (w_b[6] == 1'b0) begin
            o_entry.cls  = utf8d_pkg::CLS_CONT;
            o_entry.bits = {1'b0, w_b[5:0]};
        end else if (w_b[5] == 1'b0) begin
            o_entry.cls  = utf8d_pkg::CLS_LEAD2;
            o_entry.bits = {2'b00, w_b[4:0]};
        end else if (w_b[4] == 1'b0) begin
            o_entry.cls  = utf8d_pkg::CLS_LEAD3;
            o_entry.bits = {3'b000, w_b[3:0]};
        end else if (w_b[3] == 1'b0) begin
            o_entry.cls  = utf8d_pkg::CLS_LEAD4;
            o_entry.bits = {4'b0000, w_b[2:0]};
        end else begin
            o_entry.cls  = utf8d_pkg::CLS_BAD;
            o_entry.bits = 7'd0;
        end
    end

endmodule

// File: sv/utf8d_fifo.sv
module utf8d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_cnt,  n_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == FULL_CNT);
    assign o_empty   = (r_cnt == '0);
    assign o_data    = r_slot[r_rptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_do_push) begin
            n_wptr = (r_wptr == LAST_IDX) ? '0 : r_wptr + AW'(1);
        end
        if (w_do_pop) begin
            n_rptr = (r_rptr == LAST_IDX) ? '0 : r_rptr + AW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

// File: sv/utf8d_back.sv
module utf8d_back #(
    parameter int MAX_STRING_BYTES = utf8d_pkg::DEF_MAX_STRING_BYTES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  utf8d_pkg::t_class_word i_entry,
    input  logic                   i_avail,
    output logic                   o_take,
    input  logic                   i_res_full,
    output logic                   o_res_push,
    output utf8d_pkg::t_out_word   o_res
);

    localparam int CEIL_INT = (MAX_STRING_BYTES < 2047) ? MAX_STRING_BYTES : 2047;
    localparam logic [utf8d_pkg::COUNT_W-1:0] COUNT_CEIL = utf8d_pkg::COUNT_W'(CEIL_INT);

    logic [1:0]                    r_pend,  n_pend;
    logic [utf8d_pkg::UNIT_W-1:0]  r_pval,  n_pval;
    logic                          r_err,   n_err;
    logic [utf8d_pkg::COUNT_W-1:0] r_cnt,   n_cnt;
    logic                          w_done;
    logic [utf8d_pkg::UNIT_W-1:0]  w_unit;
    logic [utf8d_pkg::UNIT_W-1:0]  w_shift;
    logic [1:0]                    w_status;

    assign o_take  = i_avail && !i_res_full;
    assign w_shift = {r_pval[9:0], i_entry.bits[5:0]};

    always_comb begin
        n_pend = r_pend;
        n_pval = r_pval;
        n_err  = r_err;
        w_done = 1'b0;
        w_unit = '0;
        if (!r_err) begin
            if (r_pend == 2'd0) begin
                case (i_entry.cls)
                    utf8d_pkg::CLS_ASCII: begin
                        w_unit = {9'd0, i_entry.bits};
                        w_done = 1'b1;
                    end
                    utf8d_pkg::CLS_LEAD2: begin
                        n_pval = {9'd0, i_entry.bits};
                        n_pend = 2'd1;
                    end
                    utf8d_pkg::CLS_LEAD3: begin
                        n_pval = {9'd0, i_entry.bits};
                        n_pend = 2'd2;
                    end
                    utf8d_pkg::CLS_LEAD4: begin
                        n_pval = {9'd0, i_entry.bits};
                        n_pend = 2'd3;
                    end
                    default: begin
                        n_err = 1'b1;
                    end
                endcase
            end else if (i_entry.cls != utf8d_pkg::CLS_CONT) begin
                n_err = 1'b1;
            end else begin
                n_pend = r_pend - 2'd1;
                if (r_pend == 2'd1) begin
                    w_unit = w_shift;
                    w_done = 1'b1;
                    n_pval = '0;
                end else begin
                    n_pval = w_shift;
                end
            end
        end

        n_cnt = r_cnt;
        if (w_done && (r_cnt < COUNT_CEIL)) begin
            n_cnt = r_cnt + utf8d_pkg::COUNT_W'(1);
        end

        if (n_err) begin
            w_status = utf8d_pkg::ST_ILLEGAL;
        end else if (n_pend != 2'd0) begin
            w_status = utf8d_pkg::ST_TRUNCATED;
        end else begin
            w_status = utf8d_pkg::ST_OK;
        end

        o_res.unit_valid = w_done;
        o_res.code_unit  = w_unit;
        o_res.string_end = i_entry.last;
        o_res.status     = i_entry.last ? w_status : utf8d_pkg::ST_OK;
        o_res.unit_count = i_entry.last ? n_cnt : '0;
        o_res_push       = o_take && (w_done || i_entry.last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_pval <= '0;
            r_err  <= 1'b0;
            r_cnt  <= '0;
        end else if (o_take) begin
            if (i_entry.last) begin
                r_pend <= '0;
                r_pval <= '0;
                r_err  <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_pend <= n_pend;
                r_pval <= n_pval;
                r_err  <= n_err;
                r_cnt  <= n_cnt;
            end
        end
    end

endmodule

// File: sv/utf8_stream_decoder_16bit.sv
// Channel   Direction  Handshake               Payload
// input     in         push / full             i_word  (in_byte, last_byte)
// result    out        pop / empty             o_word  (unit_valid, code_unit,
//                                              string_end, status, unit_count)
//
// One byte is accepted every cycle while full is low; the back end holds its
// decode state in registers, so a byte can follow in the next cycle. A result
// reaches o_word through the class queue and then the result queue. Reset
// (synchronous, active low) empties both queues and clears the string state.
// A stall on pop fills the two-word result queue, then the four-word class
// queue, and only then raises full.
module utf8_stream_decoder_16bit #(
    parameter int MAX_STRING_BYTES = utf8d_pkg::DEF_MAX_STRING_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  utf8d_pkg::t_in_word   i_word,
    output logic                  empty,
    input  logic                  pop,
    output utf8d_pkg::t_out_word  o_word
);

    localparam int CLS_W = $bits(utf8d_pkg::t_class_word);
    localparam int RES_W = $bits(utf8d_pkg::t_out_word);

    utf8d_pkg::t_class_word w_cls_in;
    utf8d_pkg::t_class_word w_cls_out;
    utf8d_pkg::t_out_word   w_res_in;
    logic                   w_cls_empty;
    logic                   w_take;
    logic                   w_res_full;
    logic                   w_res_push;

    // Classify the incoming byte before queuing it
    utf8d_front u_front (
        .i_word  (i_word),
        .o_entry (w_cls_in)
    );

    // Decouple the classifier from the decode state
    utf8d_fifo #(
        .WIDTH (CLS_W),
        .DEPTH (utf8d_pkg::CLASS_QUEUE_DEPTH)
    ) u_cls_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_cls_in),
        .o_full  (full),
        .i_pop   (w_take),
        .o_empty (w_cls_empty),
        .o_data  (w_cls_out)
    );

    // Advance the sequence state and build results
    utf8d_back #(
        .MAX_STRING_BYTES (MAX_STRING_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (w_cls_out),
        .i_avail    (!w_cls_empty),
        .o_take     (w_take),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res      (w_res_in)
    );

    // Hold results until the consumer pops them
    utf8d_fifo #(
        .WIDTH (RES_W),
        .DEPTH (utf8d_pkg::RESULT_QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_word)
    );

endmodule

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // The unit count saturates at the smaller of the string limit and the field maximum
    localparam int COUNT_CEIL   = (utf8d_pkg::DEF_MAX_STRING_BYTES < 2047) ?
                                  utf8d_pkg::DEF_MAX_STRING_BYTES : 2047;
    // Cycles with no word moving on either side before the run is called hung
    localparam int STALL_LIMIT  = 4000;
    // Random words to push, and how many of the last ones go without any idling
    localparam int RANDOM_BYTES = 425;
    localparam int CALM_BYTES   = 80;
    // Settle time after the last expected word
    localparam int TAIL_CYCLES  = 12;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    utf8d_pkg::t_in_word  i_word;
    logic                 empty;
    logic                 pop;
    utf8d_pkg::t_out_word o_word;

    utf8_stream_decoder_16bit #(
        .MAX_STRING_BYTES(utf8d_pkg::DEF_MAX_STRING_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_word  (i_word),
        .empty   (empty),
        .pop     (pop),
        .o_word  (o_word)
    );

    // Tracks the decode state of the current string and keeps the words the
    // block owes us, oldest first.
    class utf8_decode_sb;
        logic [1:0]           pend_cnt;
        logic [15:0]          acc;
        bit                   err;
        int                   units;
        utf8d_pkg::t_out_word unit_q[$];
        int                   fails;

        function new();
            clear_string();
            fails = 0;
        endfunction

        function void clear_string();
            pend_cnt = '0;
            acc      = '0;
            err      = 1'b0;
            units    = 0;
        endfunction

        function void take_byte(utf8d_pkg::t_in_word w);
            utf8d_pkg::t_out_word res;
            bit                   done;
            logic [15:0]          unit;
            res  = '0;
            done = 1'b0;
            unit = '0;
            if (!err) begin
                if (pend_cnt == 2'd0) begin
                    if (w.in_byte < 8'h80) begin
                        unit = {8'h00, w.in_byte};
                        done = 1'b1;
                    end else if (w.in_byte < 8'hC0) begin
                        err = 1'b1;
                    end else if (w.in_byte < 8'hE0) begin
                        acc      = {11'd0, w.in_byte[4:0]};
                        pend_cnt = 2'd1;
                    end else if (w.in_byte < 8'hF0) begin
                        acc      = {12'd0, w.in_byte[3:0]};
                        pend_cnt = 2'd2;
                    end else if (w.in_byte < 8'hF8) begin
                        acc      = {13'd0, w.in_byte[2:0]};
                        pend_cnt = 2'd3;
                    end else begin
                        err = 1'b1;
                    end
                end else if (w.in_byte[7:6] != 2'b10) begin
                    err = 1'b1;
                end else begin
                    acc      = {acc[9:0], w.in_byte[5:0]};
                    pend_cnt = pend_cnt - 2'd1;
                    if (pend_cnt == 2'd0) begin
                        unit = acc;
                        done = 1'b1;
                        acc  = '0;
                    end
                end
            end
            if (done && units < COUNT_CEIL) units++;
            if (w.last_byte) begin
                res.unit_valid = done;
                res.code_unit  = unit;
                res.string_end = 1'b1;
                res.status     = err ? utf8d_pkg::ST_ILLEGAL :
                                 ((pend_cnt != 2'd0) ? utf8d_pkg::ST_TRUNCATED :
                                                       utf8d_pkg::ST_OK);
                res.unit_count = units[utf8d_pkg::COUNT_W-1:0];
                unit_q.push_back(res);
                clear_string();
            end else if (done) begin
                res.unit_valid = 1'b1;
                res.code_unit  = unit;
                unit_q.push_back(res);
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                fails++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void match_word(utf8d_pkg::t_out_word got);
            utf8d_pkg::t_out_word want;
            if (unit_q.size() == 0) begin
                fails++;
                $display("%0t: word with nothing expected, expected none actual %h", $time, got);
                return;
            end
            want = unit_q.pop_front();
            compare_field("unit_valid", 16'(want.unit_valid), 16'(got.unit_valid));
            compare_field("code_unit",  want.code_unit,       got.code_unit);
            compare_field("string_end", 16'(want.string_end), 16'(got.string_end));
            compare_field("status",     16'(want.status),     16'(got.status));
            compare_field("unit_count", 16'(want.unit_count), 16'(got.unit_count));
        endfunction
    endclass

    utf8_decode_sb tracker = new();

    logic [7:0] str_q[$];     // bytes of the string about to be sent
    bit         tx_idle_on;   // sender may idle in this stretch
    bit         rx_idle_on;   // receiver may stall in this stretch
    bit         calm;         // final stretch: no idling on either side
    int         sent;         // words accepted so far
    int         quiet_cycles;

    // Free-running clock, 10 ns period
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog: count cycles in which no word moves on either side
    initial quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("utf8_stream_decoder_16bit: mismatch");
            $finish;
        end
    end

    // Receiver: check each popped word against the oldest expectation, then
    // decide whether to stall. Stalls come in bursts.
    initial begin
        int stall_left;
        stall_left = 0;
        pop        = 1'b0;
        rx_idle_on = 1'b1;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) tracker.match_word(o_word);
            // flip between stalling and free-flowing stretches now and then
            if ($urandom_range(0, 99) == 0) rx_idle_on = !rx_idle_on;
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (stall_left > 0 && !calm) begin
                pop <= 1'b0;
                stall_left--;
            end else if (!calm && rx_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                pop <= 1'b0;
            end else begin
                stall_left = 0;
                pop <= 1'b1;
            end
        end
    end

    // Push one word and hold it until the block takes it. Push stays high into
    // the next word unless an idle burst is drawn first.
    task automatic send_byte(input logic [7:0] b, input bit last);
        utf8d_pkg::t_in_word w;
        w.in_byte   = b;
        w.last_byte = last;
        if (tx_idle_on && !calm && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (full);
        tracker.take_byte(w);
        sent++;
    endtask

    // Send the staged string, flagging its final byte
    task automatic send_string();
        foreach (str_q[i]) send_byte(str_q[i], i == str_q.size() - 1);
    endtask

    // Hold the sender until every expected word has come back
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (tracker.unit_q.size() != 0);
    endtask

    // Append one character: kind 0 is ASCII, kinds 1..3 are 2..4 byte
    // sequences. ncont continuation bytes follow the lead; fewer than kind
    // leaves the sequence cut short.
    function automatic void add_char(int kind, int ncont);
        case (kind)
            0:       str_q.push_back({1'b0, 7'($urandom_range(0, 127))});
            1:       str_q.push_back({3'b110, 5'($urandom_range(0, 31))});
            2:       str_q.push_back({4'b1110, 4'($urandom_range(0, 15))});
            default: str_q.push_back({5'b11110, 3'($urandom_range(0, 7))});
        endcase
        repeat (ncont) str_q.push_back({2'b10, 6'($urandom_range(0, 63))});
    endfunction

    // Build a random string: mostly well-formed characters, with a fault
    // dropped in now and then.
    task automatic build_string();
        int kind;
        int pos;
        str_q.delete();
        repeat ($urandom_range(1, 12)) begin
            kind = $urandom_range(0, 3);
            add_char(kind, kind);
        end
        case ($urandom_range(0, 9))
            0: begin
                // stray continuation byte
                pos = $urandom_range(0, str_q.size());
                str_q.insert(pos, {2'b10, 6'($urandom_range(0, 63))});
            end
            1: begin
                // lead byte that no legal sequence starts with
                pos = $urandom_range(0, str_q.size());
                str_q.insert(pos, {5'b11111, 3'($urandom_range(0, 7))});
            end
            2: begin
                // sequence still open when the string ends
                kind = $urandom_range(1, 3);
                add_char(kind, $urandom_range(0, kind - 1));
            end
            3: begin
                // plain noise over one byte
                pos = $urandom_range(0, str_q.size() - 1);
                str_q[pos] = 8'($urandom_range(0, 255));
            end
            default: ;
        endcase
    endtask

    // Sender and run control
    initial begin
        int rand_start;
        push       = 1'b0;
        i_word     = '0;
        i_rst_n    = 1'b0;
        tx_idle_on = 1'b1;
        calm       = 1'b0;
        sent       = 0;

        // hold reset, then release it before the first string
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ASCII extremes, 2/3/4 byte sequences (4-byte keeps low 16 bits)
        str_q = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                  8'hF0, 8'h9F, 8'h98, 8'h80, 8'h41};
        send_string();
        // illegal lead byte as the whole string
        str_q = '{8'hFF};
        send_string();
        // stray continuation, then bytes that must be ignored
        str_q = '{8'h80, 8'h41, 8'h42};
        send_string();
        // bad continuation: ASCII where a continuation is owed
        str_q = '{8'hE2, 8'h41, 8'h42};
        send_string();
        // sequence cut off by the end of the string
        str_q = '{8'h41, 8'hE2, 8'h82};
        send_string();
        // unit completed by the final byte itself
        str_q = '{8'hC3, 8'hBF};
        send_string();

        // let everything out before the random strings
        drain();

        // Random strings; the tail end runs with no idling at all
        rand_start = sent;
        while (sent - rand_start < RANDOM_BYTES) begin
            if (RANDOM_BYTES - (sent - rand_start) <= CALM_BYTES) calm = 1'b1;
            tx_idle_on = ($urandom_range(0, 3) != 0);
            build_string();
            send_string();
            if (!calm && $urandom_range(0, 24) == 0) drain();
        end

        // wait out the remaining words, then a short settle
        push <= 1'b0;
        while (tracker.unit_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (tracker.fails == 0 && tracker.unit_q.size() == 0) begin
            $display("utf8_stream_decoder_16bit: match");
        end else begin
            $display("utf8_stream_decoder_16bit: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
sv/utf8d_pkg.sv
sv/utf8d_front.sv
sv/utf8d_fifo.sv
sv/utf8d_back.sv
sv/utf8_stream_decoder_16bit.sv
tb/tb_top.sv
